// ===== design/text_console_glyph_renderer_unit_macros.svh =====
// Assertion macros for the glyph renderer.
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// ante |-> cons, same cycle
`define TCGR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcgr: same-cycle check failed");
// ante |=> cons, next cycle
`define TCGR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcgr: next-cycle check failed");
`else
`define TCGR_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define TCGR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== design/tcgr_pkg.sv =====
package tcgr_pkg;

  localparam int GLYPH_COUNT = 256;
  localparam int GLYPH_ROWS  = 8;
  localparam int GLYPH_BITS  = 64;
  localparam int FONT_DEPTH  = GLYPH_COUNT * GLYPH_ROWS;
  localparam int FONT_AW     = $clog2(FONT_DEPTH);

  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 32;

  // input kinds
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_DRAW = 2'd1;
  localparam logic [1:0] KIND_HOME = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FONT_SCALE   = 1'd1;

  localparam logic [12:0] SCREEN_WIDTH_RST = 13'd640;
  localparam logic [3:0]  FONT_SCALE_RST   = 4'd1;
  localparam logic [7:0]  NEWLINE_CODE     = 8'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRAP,
    ST_NL,
    ST_LOAD,
    ST_LWAIT,
    ST_EMIT,
    ST_ADV
  } state_t;

  typedef struct packed {
    logic take;      // latch the character code
    logic font_wr;   // write a font row from the input item
    logic home;
    logic wrap;      // line advance if the glyph does not fit
    logic line_adv;
    logic rd;        // read the next glyph row
    logic emit;      // send one square
    logic advance;   // move cursor_x past the glyph
  } cmd_t;

  typedef struct packed {
    logic is_newline;
    logic in_range;
    logic rd_last;
    logic glyph_empty;
    logic out_free;
  } sts_t;

endpackage

// ===== design/tcgr_ctrl.sv =====
module tcgr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        in_kind,
  output logic              in_ready,
  input  tcgr_pkg::sts_t    sts,
  output tcgr_pkg::cmd_t    cmd
);

  tcgr_pkg::state_t state;
  tcgr_pkg::state_t state_next;
  logic             acc;

  assign in_ready = (state == tcgr_pkg::ST_IDLE);
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcgr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tcgr_pkg::ST_IDLE: begin
        if (acc && in_kind == tcgr_pkg::KIND_DRAW) state_next = tcgr_pkg::ST_WRAP;
      end
      tcgr_pkg::ST_WRAP: begin
        if (sts.is_newline) state_next = tcgr_pkg::ST_NL;
        else if (!sts.in_range) state_next = tcgr_pkg::ST_ADV;
        else state_next = tcgr_pkg::ST_LOAD;
      end
      tcgr_pkg::ST_NL:    state_next = tcgr_pkg::ST_IDLE;
      tcgr_pkg::ST_LOAD: begin
        if (sts.rd_last) state_next = tcgr_pkg::ST_LWAIT;
      end
      tcgr_pkg::ST_LWAIT: state_next = tcgr_pkg::ST_EMIT;
      tcgr_pkg::ST_EMIT: begin
        if (sts.glyph_empty) state_next = tcgr_pkg::ST_ADV;
      end
      tcgr_pkg::ST_ADV:   state_next = tcgr_pkg::ST_IDLE;
      default:            state_next = tcgr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      tcgr_pkg::ST_IDLE: begin
        cmd.take    = acc && in_kind == tcgr_pkg::KIND_DRAW;
        cmd.font_wr = acc && in_kind == tcgr_pkg::KIND_LOAD;
        cmd.home    = acc && in_kind == tcgr_pkg::KIND_HOME;
      end
      tcgr_pkg::ST_WRAP:  cmd.wrap     = 1'b1;
      tcgr_pkg::ST_NL:    cmd.line_adv = 1'b1;
      tcgr_pkg::ST_LOAD:  cmd.rd       = 1'b1;
      tcgr_pkg::ST_LWAIT: cmd          = '0;
      tcgr_pkg::ST_EMIT:  cmd.emit     = !sts.glyph_empty && sts.out_free;
      tcgr_pkg::ST_ADV:   cmd.advance  = 1'b1;
      default:            cmd          = '0;
    endcase
  end

endmodule

// ===== design/tcgr_datapath.sv =====
module tcgr_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  tcgr_pkg::cmd_t                    cmd,
  output tcgr_pkg::sts_t                    sts,
  input  logic [7:0]                        in_code,
  input  logic [2:0]                        in_row,
  input  logic [7:0]                        in_bits,
  input  logic                              cfg_we,
  input  logic [tcgr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcgr_pkg::CFG_W-1:0]        cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [15:0]                       out_x,
  output logic [15:0]                       out_y,
  output logic                              out_last
);

  logic [7:0]  font_mem [tcgr_pkg::FONT_DEPTH];
  logic [7:0]  rdata;
  logic [tcgr_pkg::FONT_AW-1:0] wr_addr;
  logic [tcgr_pkg::FONT_AW-1:0] rd_addr;
  logic        wr_in_range;

  logic [12:0] screen_width;
  logic [3:0]  font_scale;
  logic [15:0] cursor_x;
  logic [15:0] cursor_x_next;
  logic [15:0] cursor_y;
  logic [15:0] cursor_y_next;
  logic [7:0]  code;
  logic [2:0]  rd_row;
  logic        rd_vld;
  logic [tcgr_pkg::GLYPH_BITS-1:0] glyph;
  logic [tcgr_pkg::GLYPH_BITS-1:0] low;
  logic [tcgr_pkg::GLYPH_BITS-1:0] rest;
  logic [5:0]  bit_idx;

  logic [6:0]  cell_w;     // 8 * scale
  logic [7:0]  line_h;     // 9 * scale
  logic [16:0] wrap_sum;
  logic        wrap_hit;
  logic [6:0]  col_off;
  logic [6:0]  row_off;

  // font store, no reset
  assign wr_in_range = {1'b0, in_code} < 9'(tcgr_pkg::GLYPH_COUNT);
  assign wr_addr     = tcgr_pkg::FONT_AW'({in_code, in_row});
  assign rd_addr     = tcgr_pkg::FONT_AW'({code, rd_row});

  always_ff @(posedge clk) begin
    if (cmd.font_wr && wr_in_range) begin
      font_mem[wr_addr] <= in_bits;
    end
    rdata <= font_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= tcgr_pkg::SCREEN_WIDTH_RST;
      font_scale   <= tcgr_pkg::FONT_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcgr_pkg::REG_SCREEN_WIDTH: screen_width <= cfg_data;
        tcgr_pkg::REG_FONT_SCALE:   font_scale   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign cell_w   = {font_scale, 3'b000};
  assign line_h   = {1'b0, font_scale, 3'b000} + {4'd0, font_scale};
  assign wrap_sum = {1'b0, cursor_x} + {10'd0, cell_w};
  assign wrap_hit = wrap_sum >= {4'd0, screen_width};

  always_comb begin
    cursor_x_next = cursor_x;
    cursor_y_next = cursor_y;
    priority if (cmd.home) begin
      cursor_x_next = '0;
      cursor_y_next = '0;
    end else if ((cmd.wrap && wrap_hit) || cmd.line_adv) begin
      cursor_x_next = '0;
      cursor_y_next = cursor_y + {8'd0, line_h};
    end else if (cmd.advance) begin
      cursor_x_next = cursor_x + {9'd0, cell_w};
    end else begin
      cursor_x_next = cursor_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
      rd_row   <= '0;
      rd_vld   <= 1'b0;
    end else begin
      cursor_x <= cursor_x_next;
      cursor_y <= cursor_y_next;
      rd_vld   <= cmd.rd;
      if (cmd.take) begin
        rd_row <= '0;
      end else if (cmd.rd) begin
        rd_row <= rd_row + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      code <= in_code;
    end
  end

  // rows shift in from the top so row 0 ends in the low byte
  always_comb begin
    low     = glyph & (~glyph + 64'd1);
    rest    = glyph & ~low;
    bit_idx = '0;
    for (int i = 0; i < tcgr_pkg::GLYPH_BITS; i++) begin
      if (low[i]) bit_idx = bit_idx | 6'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      glyph <= {rdata, glyph[tcgr_pkg::GLYPH_BITS-1:8]};
    end else if (cmd.emit) begin
      glyph <= rest;
    end
  end

  assign col_off = 7'(bit_idx[2:0]) * 7'(font_scale);
  assign row_off = 7'(bit_idx[5:3]) * 7'(font_scale);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_x    <= cursor_x + {9'd0, col_off};
      out_y    <= cursor_y + {9'd0, row_off};
      out_last <= (rest == '0);
    end
  end

  assign sts.is_newline  = (code == tcgr_pkg::NEWLINE_CODE);
  assign sts.in_range    = {1'b0, code} < 9'(tcgr_pkg::GLYPH_COUNT);
  assign sts.rd_last     = (rd_row == 3'd7);
  assign sts.glyph_empty = (glyph == '0);
  assign sts.out_free    = !out_valid || out_ready;

endmodule

// ===== design/text_console_glyph_renderer_unit.sv =====
// Font load, home and ignored kinds leave the control idle, ready for more input.
// Newline: wrap, then line advance. Drawn character: wrap, eight glyph row reads,
// a wait state, one square per set glyph bit (one per cycle while the sink is
// ready), then cursor advance. The rate is set by the eight reads of the single
// font store read port and the one square a cycle output register. Synchronous
// reset clears cursor, config and control; no pass clears the font store after it.
`include "text_console_glyph_renderer_unit_macros.svh"

module text_console_glyph_renderer_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // char_code[7:0], row_index[10:8], row_bits[18:11], zero pad
  input  logic [tcgr_pkg::IN_DATA_W-1:0]  s_tdata,
  // kind[1:0]
  input  logic [1:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // cell_x[15:0], cell_y[31:16]
  output logic [tcgr_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tlast,
  input  logic                            cfg_we,
  input  logic [tcgr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcgr_pkg::CFG_W-1:0]      cfg_data
);

  tcgr_pkg::cmd_t cmd;
  tcgr_pkg::sts_t sts;
  logic [15:0]    cell_x;
  logic [15:0]    cell_y;

  tcgr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcgr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_code   (s_tdata[7:0]),
    .in_row    (s_tdata[10:8]),
    .in_bits   (s_tdata[18:11]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_x     (cell_x),
    .out_y     (cell_y),
    .out_last  (m_tlast)
  );

  assign m_tdata = {cell_y, cell_x};

  // a drawn character keeps the input closed while it is worked on
  `TCGR_ASSERT_NEXT(a_draw_busy, clk, rst, s_tvalid && s_tready && s_tuser == tcgr_pkg::KIND_DRAW, !s_tready)
  // font loads and homes leave the input ready for the next item
  `TCGR_ASSERT_NEXT(a_load_quick, clk, rst, s_tvalid && s_tready && (s_tuser == tcgr_pkg::KIND_LOAD || s_tuser == tcgr_pkg::KIND_HOME), s_tready)
  // a new square only appears while a character is in progress
  `TCGR_ASSERT_NOW(a_emit_busy, clk, rst, $rose(m_tvalid), !s_tready)

endmodule

// ===== tb/glyph_square_checker.sv =====
module glyph_square_checker
  import tcgr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  // char_code[7:0], row_index[10:8], row_bits[18:11], zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // kind[1:0]
  input  logic [1:0]            s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  // cell_x[15:0], cell_y[31:16]
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  output int                    fail_count,
  output int                    squares_pending
);

  localparam int CELL_STEP    = 8;
  localparam int LINE_STEP    = 9;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic        tail;
  } square_t;

  logic [7:0]  glyph_rows [FONT_DEPTH];
  logic [15:0] pen_x;
  logic [15:0] pen_y;
  logic [12:0] wrap_width;
  logic [3:0]  cell_side;
  square_t     squares_due [$];
  int          mismatches = 0;

  task automatic next_line();
    pen_y = pen_y + 16'(LINE_STEP * int'(cell_side));
    pen_x = '0;
  endtask

  task automatic render_item(input logic [1:0] kind, input logic [7:0] code,
                             input logic [2:0] row, input logic [7:0] bits);
    square_t sq;
    int      total;
    int      sent;
    int      r;
    int      c;
    total = 0;
    sent  = 0;
    case (kind)
      KIND_LOAD: begin
        if (int'(code) < GLYPH_COUNT) glyph_rows[{code, row}] = bits;
      end
      KIND_HOME: begin
        pen_x = '0;
        pen_y = '0;
      end
      KIND_DRAW: begin
        // wrap test runs before every character, newline included
        if (int'(pen_x) + CELL_STEP * int'(cell_side) >= int'(wrap_width)) next_line();
        if (code == NEWLINE_CODE) begin
          next_line();
        end else begin
          if (int'(code) < GLYPH_COUNT) begin
            for (r = 0; r < GLYPH_ROWS; r++) total += $countones(glyph_rows[{code, 3'(r)}]);
            for (r = 0; r < GLYPH_ROWS; r++) begin
              for (c = 0; c < 8; c++) begin
                if (glyph_rows[{code, 3'(r)}][c]) begin
                  sent++;
                  sq.x    = pen_x + 16'(c * int'(cell_side));
                  sq.y    = pen_y + 16'(r * int'(cell_side));
                  sq.tail = (sent == total);
                  squares_due.push_back(sq);
                end
              end
            end
          end
          pen_x = pen_x + 16'(CELL_STEP * int'(cell_side));
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    square_t sq;
    if (rst) begin
      pen_x      = '0;
      pen_y      = '0;
      wrap_width = SCREEN_WIDTH_RST;
      cell_side  = FONT_SCALE_RST;
      squares_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (squares_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("checker: square with nothing due: x=%0d y=%0d last=%0b",
                     m_tdata[15:0], m_tdata[31:16], m_tlast);
        end else begin
          sq = squares_due.pop_front();
          if (m_tdata[15:0] !== sq.x || m_tdata[31:16] !== sq.y || m_tlast !== sq.tail) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("checker: square mismatch: exp x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                       sq.x, sq.y, sq.tail, m_tdata[15:0], m_tdata[31:16], m_tlast);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SCREEN_WIDTH: wrap_width = cfg_data[12:0];
          REG_FONT_SCALE:   cell_side  = cfg_data[3:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        render_item(s_tuser, s_tdata[7:0], s_tdata[10:8], s_tdata[18:11]);
    end
    fail_count      <= mismatches;
    squares_pending <= squares_due.size();
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import tcgr_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;  // unused kind, dropped by the block
  localparam int HOLD_CYCLES   = 600;
  localparam int SETTLE_CYCLES = 24;
  localparam int TAIL_CYCLES   = 100;
  localparam int MIX_ITEMS     = 36;
  localparam logic [7:0] GLYPH_A [8] = '{8'h01, 8'h80, 8'h00, 8'h3C,
                                         8'h42, 8'h7E, 8'h81, 8'hFF};

  typedef enum logic [1:0] {FILL_BLANK, FILL_SOLID, FILL_MIXED} fill_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [1:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  int                    fail_count;
  int                    squares_pending;

  logic                  idle_on;
  logic                  hold_go;
  bit   [7:0]            rows_loaded [256];
  bit                    listed [256];
  logic [7:0]            drawable [$];

  text_console_glyph_renderer_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  glyph_square_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tlast         (m_tlast),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .squares_pending (squares_pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic offer(input logic [1:0] kind, input logic [7:0] code,
                       input logic [2:0] row, input logic [7:0] bits);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {5'd0, bits, row, code};
    do @(posedge clk); while (!s_tready);
  endtask

  // only glyphs with all eight rows written may be drawn
  task automatic load_row(input logic [7:0] code, input logic [2:0] row,
                          input logic [7:0] bits);
    offer(KIND_LOAD, code, row, bits);
    rows_loaded[code][row] = 1'b1;
    if (rows_loaded[code] == 8'hFF && !listed[code]) begin
      listed[code] = 1'b1;
      drawable.push_back(code);
    end
  endtask

  task automatic load_glyph(input logic [7:0] code, input fill_t fill);
    int         r;
    logic [7:0] bits;
    for (r = 0; r < GLYPH_ROWS; r++) begin
      case (fill)
        FILL_BLANK: bits = 8'h00;
        FILL_SOLID: bits = 8'hFF;
        default: begin
          case ($urandom_range(0, 3))
            0:       bits = 8'h00;
            1:       bits = 8'hFF;
            2:       bits = 8'h01 << $urandom_range(0, 7);
            default: bits = 8'($urandom);
          endcase
        end
      endcase
      load_row(code, 3'(r), bits);
    end
  endtask

  task automatic draw(input logic [7:0] code);
    offer(KIND_DRAW, code, 3'($urandom_range(0, 7)), 8'($urandom));
  endtask

  task automatic apply_setting(input logic [12:0] width, input logic [3:0] scale);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data  <= width;
    @(posedge clk);
    cfg_index <= REG_FONT_SCALE;
    cfg_data  <= {9'($urandom), scale};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // blank glyphs and newlines leave nothing due while still busy, hence the pad
  task automatic drain(input int pad);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (squares_pending != 0) @(posedge clk);
    repeat (pad) @(posedge clk);
  endtask

  task automatic run_mix(input int count);
    int         done;
    int         pick;
    int         n;
    int         k;
    logic [7:0] code;
    fill_t      fill;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        code = 8'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 2) fill = FILL_BLANK;
        else if (pick < 4) fill = FILL_SOLID;
        else fill = FILL_MIXED;
        load_glyph(code, fill);
        done += GLYPH_ROWS;
      end else if (pick < 17) begin
        // interrupted load, a few scattered rows
        code = 8'($urandom);
        n = $urandom_range(1, 7);
        for (k = 0; k < n; k++) load_row(code, 3'($urandom_range(0, 7)), 8'($urandom));
        done += n;
      end else if (pick < 77) begin
        if (drawable.size() == 0) draw(NEWLINE_CODE);
        else draw(drawable[$urandom_range(0, drawable.size() - 1)]);
        done++;
      end else if (pick < 87) begin
        draw(NEWLINE_CODE);
        done++;
      end else if (pick < 92) begin
        offer(KIND_HOME, 8'($urandom), 3'($urandom), 8'($urandom));
        done++;
      end else begin
        offer(KIND_SPARE, 8'($urandom), 3'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin : sink
    int n;
    bit held;
    held = 1'b0;
    m_tready <= 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_go && !held) begin
        // long back-pressure so the block fills and stalls its input
        held = 1'b1;
        m_tready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int k;
    int p;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= KIND_LOAD;
    cfg_we    <= 1'b0;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data  <= '0;
    idle_on   <= 1'b1;
    hold_go   <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: edge pixels, blank row, full glyph, newline, home, unused kind
    for (k = 0; k < GLYPH_ROWS; k++) load_row(8'h41, 3'(k), GLYPH_A[k]);
    load_glyph(8'hFF, FILL_SOLID);
    draw(8'h41);
    draw(8'hFF);
    draw(NEWLINE_CODE);
    draw(8'h41);
    offer(KIND_HOME, 8'($urandom), 3'($urandom), 8'($urandom));
    offer(KIND_SPARE, 8'($urandom), 3'($urandom), 8'($urandom));
    draw(8'hFF);
    drain(SETTLE_CYCLES);

    for (p = 0; p < 6; p++) begin
      case (p)
        0:       apply_setting(13'h1FFF, 4'hF);
        1:       apply_setting(13'd0, 4'd0);
        2:       apply_setting(13'd8, 4'd1);
        3:       apply_setting(13'd4096, 4'd8);
        4:       apply_setting(13'd640, 4'd2);
        default: apply_setting(13'($urandom), 4'($urandom));
      endcase
      idle_on <= (p != 4);
      hold_go <= (p == 3);
      run_mix(MIX_ITEMS);
      drain(SETTLE_CYCLES);
    end

    idle_on <= 1'b0;
    apply_setting(13'($urandom_range(8, 4096)), 4'($urandom_range(1, 8)));
    run_mix(MIX_ITEMS);
    drain(TAIL_CYCLES);

    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #6_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
